// ----- design/vocab_prob_prune_topk_cumulative_defines.svh -----
// Assertion macros used by the checker file of the vocabulary pruning block.
`ifndef VOCAB_PROB_PRUNE_TOPK_CUMULATIVE_DEFINES_SVH
`define VOCAB_PROB_PRUNE_TOPK_CUMULATIVE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define VPP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vpp checker: property failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define VPP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vpp checker: property failed");

`endif

// ----- design/vpp_pkg.sv -----
// Package with shared constants and types of the vocabulary pruning block.
`timescale 1ns / 1ps
`default_nettype none

package vpp_pkg;

	localparam int VOCAB_SIZE_DEF = 32;
	localparam int PROB_BITS_DEF  = 16;

	// Configuration port
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = ADDR_W - 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CUTOFF     = 1'b0,
		REG_KEEP_TOP_N = 1'b1
	} reg_index_t;

	localparam logic [ADDR_W-1:0] ADDR_KEEP_TOP_N = 3'd4;

	localparam int              TOPN_W     = 7;
	localparam logic [TOPN_W-1:0] TOPN_RESET = 7'd64;

	// Result fields
	localparam int INDEX_OUT_W = 6;
	localparam int LOG_W       = 16;
	localparam logic [LOG_W-1:0] LOG_MIN = 16'h8000;

	// Log unit
	localparam int MANT_W    = 16;
	localparam int SQ_STEPS  = 16;
	localparam int ROUND_SH  = 21;
	localparam logic [MANT_W-1:0] LN2_Q16 = 16'd45426;

	// Queue between the front and back parts
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

// ----- design/vpp_cfg.sv -----
// Configuration registers of the vocabulary pruning block behind an APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module vpp_cfg #(
	parameter int PROB_BITS = vpp_pkg::PROB_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [vpp_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [vpp_pkg::DATA_W-1:0]      pwdata,
	output logic      [vpp_pkg::DATA_W-1:0]      prdata,
	output logic                                 pready,
	output logic      [PROB_BITS:0]              cutoff,
	output logic      [vpp_pkg::TOPN_W-1:0]      keep_top_n
);

	localparam logic [PROB_BITS:0] ONE = (PROB_BITS+1)'(1) << PROB_BITS;

	logic [PROB_BITS:0]         cutoff_q;
	logic [vpp_pkg::TOPN_W-1:0] keep_q;
	vpp_pkg::reg_index_t        reg_idx;
	logic                       wr_en;

	assign reg_idx = vpp_pkg::reg_index_t'(paddr[vpp_pkg::ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= ONE;
			keep_q   <= vpp_pkg::TOPN_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				vpp_pkg::REG_CUTOFF:     cutoff_q <= pwdata[PROB_BITS:0];
				vpp_pkg::REG_KEEP_TOP_N: keep_q   <= pwdata[vpp_pkg::TOPN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			vpp_pkg::REG_CUTOFF:     prdata = vpp_pkg::DATA_W'(cutoff_q);
			vpp_pkg::REG_KEEP_TOP_N: prdata = vpp_pkg::DATA_W'(keep_q);
			default:                 prdata = '0;
		endcase
	end

	assign cutoff     = cutoff_q;
	assign keep_top_n = keep_q;

endmodule

`default_nettype wire

// ----- design/vpp_front.sv -----
// Front part: insertion-sort cell row, arrival store and selection of kept entries.
`timescale 1ns / 1ps
`default_nettype none

module vpp_front #(
	parameter int VOCAB_SIZE = vpp_pkg::VOCAB_SIZE_DEF,
	parameter int PROB_BITS  = vpp_pkg::PROB_BITS_DEF,
	localparam int IDX_W     = $clog2(VOCAB_SIZE),
	localparam int PKT_W     = 1 + IDX_W + PROB_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          entry_valid,
	output logic                               entry_ready,
	input  wire logic [PROB_BITS-1:0]          probability,
	input  wire logic                          last_entry,
	input  wire logic [PROB_BITS:0]            cutoff,
	input  wire logic [vpp_pkg::TOPN_W-1:0]    keep_top_n,
	input  wire logic [vpp_pkg::QLVL_W-1:0]    q_level,
	output logic                               push,
	output logic      [PKT_W-1:0]              push_data
);

	localparam int CNT_W = $clog2(VOCAB_SIZE + 1);
	localparam int CMP_W = vpp_pkg::TOPN_W + 1;
	localparam int SUM_W = PROB_BITS + 1;
	localparam int RAW_W = PROB_BITS + 2;
	localparam int LVL_W = vpp_pkg::QLVL_W + 1;
	localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << PROB_BITS;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ARRIVAL,
		ST_CUM,
		ST_TOPN
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   k_q;
	logic [SUM_W-1:0]   sum_q;

	// Sorted cell row, highest probability in cell 0.
	logic [PROB_BITS-1:0] sp_q [VOCAB_SIZE];
	logic [IDX_W-1:0]     si_q [VOCAB_SIZE];
	logic [PROB_BITS-1:0] arr_mem [VOCAB_SIZE];

	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [PROB_BITS-1:0] sprob_s1;
	logic                 from_mem_s1;
	logic                 last_s1;
	logic [PROB_BITS-1:0] arr_rd_s1;

	logic                  accept;
	logic                  has_room;
	logic [CNT_W-1:0]      n_new;
	logic                  cum_en;
	logic                  topn_limits;
	logic [VOCAB_SIZE-1:0] ge;
	logic                  issue;
	logic                  issue_last;
	logic [CMP_W-1:0]      kp1;
	logic [CMP_W-1:0]      n_cur;
	logic [CMP_W-1:0]      keep_c;
	logic [RAW_W-1:0]      sum_raw;
	logic [SUM_W-1:0]      sum_sat;

	assign entry_ready = (state_q == ST_LOAD);
	assign accept      = entry_valid && entry_ready;
	assign has_room    = count_q < CNT_W'(VOCAB_SIZE);
	assign n_new       = count_q + CNT_W'(has_room);
	assign cum_en      = cutoff < ONE;
	assign keep_c      = CMP_W'(keep_top_n);
	assign topn_limits = keep_c < CMP_W'(n_new);
	assign kp1         = CMP_W'(k_q) + CMP_W'(1);
	assign n_cur       = CMP_W'(count_q);

	// A cell holds its value when it is valid and not below the new entry;
	// equal values stay ahead, so ties keep the lower arrival index first.
	always_comb begin
		for (int i = 0; i < VOCAB_SIZE; i++) begin
			ge[i] = (CNT_W'(i) < count_q) && (sp_q[i] >= probability);
		end
	end

	assign sum_raw = RAW_W'(sum_q) + RAW_W'(sp_q[0]);
	assign sum_sat = (sum_raw > RAW_W'(ONE)) ? ONE : sum_raw[SUM_W-1:0];

	// One slot is kept free for the entry already in flight in stage 1.
	assign issue = (state_q != ST_LOAD) &&
		((LVL_W'(q_level) + LVL_W'(valid_s1)) < LVL_W'(vpp_pkg::QUEUE_DEPTH));

	always_comb begin
		unique case (state_q) inside
			ST_ARRIVAL: issue_last = (kp1 == n_cur);
			ST_TOPN:    issue_last = (kp1 == keep_c);
			ST_CUM:     issue_last = (sum_sat >= cutoff) || (kp1 >= keep_c) || (kp1 == n_cur);
			default:    issue_last = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			count_q  <= '0;
			k_q      <= '0;
			sum_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			unique case (state_q) inside
				ST_LOAD: begin
					if (accept) begin
						k_q   <= '0;
						sum_q <= '0;
						// Nothing is kept: the time step closes here.
						if (last_entry && !cum_en && keep_top_n == '0) begin
							count_q <= '0;
						end else begin
							count_q <= n_new;
						end
						if (last_entry) begin
							if (!cum_en && !topn_limits) begin
								state_q <= ST_ARRIVAL;
							end else if (cum_en) begin
								state_q <= ST_CUM;
							end else if (keep_top_n != '0) begin
								state_q <= ST_TOPN;
							end
						end
					end
				end
				ST_ARRIVAL, ST_CUM, ST_TOPN: begin
					if (issue) begin
						if (issue_last) begin
							state_q <= ST_LOAD;
							count_q <= '0;
							k_q     <= '0;
							sum_q   <= '0;
						end else begin
							k_q <= k_q + IDX_W'(1);
							if (state_q == ST_CUM) begin
								sum_q <= sum_sat;
							end
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_room) begin
			arr_mem[IDX_W'(count_q)] <= probability;
			if (!ge[0]) begin
				sp_q[0] <= probability;
				si_q[0] <= IDX_W'(count_q);
			end
			for (int i = 1; i < VOCAB_SIZE; i++) begin
				if (!ge[i]) begin
					if (ge[i-1]) begin
						sp_q[i] <= probability;
						si_q[i] <= IDX_W'(count_q);
					end else begin
						sp_q[i] <= sp_q[i-1];
						si_q[i] <= si_q[i-1];
					end
				end
			end
		end else if (issue && state_q != ST_ARRIVAL) begin
			for (int i = 0; i < VOCAB_SIZE - 1; i++) begin
				sp_q[i] <= sp_q[i+1];
				si_q[i] <= si_q[i+1];
			end
		end

		if (issue) begin
			arr_rd_s1   <= arr_mem[k_q];
			idx_s1      <= (state_q == ST_ARRIVAL) ? k_q : si_q[0];
			sprob_s1    <= sp_q[0];
			from_mem_s1 <= (state_q == ST_ARRIVAL);
			last_s1     <= issue_last;
		end
	end

	assign push      = valid_s1;
	assign push_data = {last_s1, idx_s1, (from_mem_s1 ? arr_rd_s1 : sprob_s1)};

endmodule

`default_nettype wire

// ----- design/vpp_queue.sv -----
// Short queue that decouples entry selection from the log conversion.
`timescale 1ns / 1ps
`default_nettype none

module vpp_queue #(
	parameter int PKT_W = 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire logic [PKT_W-1:0]            push_data,
	input  wire logic                        pop,
	output logic      [PKT_W-1:0]            pop_data,
	output logic                             not_empty,
	output logic      [vpp_pkg::QLVL_W-1:0]  level
);

	logic [PKT_W-1:0]            slot_q [vpp_pkg::QUEUE_DEPTH];
	logic [vpp_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [vpp_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [vpp_pkg::QLVL_W-1:0]  level_q;
	logic                        do_pop;

	// The writer only pushes when a slot is free.
	assign do_pop    = pop && (level_q != '0);
	assign not_empty = (level_q != '0);
	assign level     = level_q;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + vpp_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + vpp_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				level_q <= level_q + vpp_pkg::QLVL_W'(1);
			end else if (!push && do_pop) begin
				level_q <= level_q - vpp_pkg::QLVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- design/vpp_back.sv -----
// Back part: iterative natural-log conversion and the result output register.
`timescale 1ns / 1ps
`default_nettype none

module vpp_back #(
	parameter int VOCAB_SIZE = vpp_pkg::VOCAB_SIZE_DEF,
	parameter int PROB_BITS  = vpp_pkg::PROB_BITS_DEF,
	localparam int IDX_W     = $clog2(VOCAB_SIZE),
	localparam int PKT_W     = 1 + IDX_W + PROB_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              q_valid,
	input  wire logic [PKT_W-1:0]                  q_data,
	output logic                                   pop,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output logic      [vpp_pkg::INDEX_OUT_W-1:0]   token_index,
	output logic signed [vpp_pkg::LOG_W-1:0]       log_probability,
	output logic                                   last_result
);

	localparam int MANT_W  = vpp_pkg::MANT_W;
	localparam int E_W     = $clog2(PROB_BITS);
	localparam int EX_W    = $clog2(PROB_BITS + 1);
	localparam int SH_W    = PROB_BITS + MANT_W - 1;
	localparam int MAG_W   = EX_W + MANT_W;
	localparam int PROD_W  = MAG_W + MANT_W;
	localparam int RND_W   = PROD_W + 1;
	localparam int R_W     = RND_W - vpp_pkg::ROUND_SH;
	localparam int STEP_W  = $clog2(vpp_pkg::SQ_STEPS);
	localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (vpp_pkg::ROUND_SH - 1);
	localparam logic [R_W-1:0]   R_SAT      = R_W'(32768);

	typedef enum logic [1:0] {
		B_IDLE,
		B_SQ,
		B_MUL,
		B_OUT
	} state_t;

	state_t                state_q;
	logic [STEP_W-1:0]     step_q;
	logic                  result_valid_q;
	logic [IDX_W-1:0]      token_index_q;
	logic [vpp_pkg::LOG_W-1:0] log_q;
	logic                  last_result_q;

	logic [MANT_W-1:0]     y_q;
	logic [MANT_W-1:0]     frac_q;
	logic [E_W-1:0]        e_q;
	logic                  zero_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  last_q;
	logic [PROD_W-1:0]     prod_q;

	logic [PROB_BITS-1:0]  p_in;
	logic [IDX_W-1:0]      idx_in;
	logic                  last_in;
	logic [E_W-1:0]        lead_c;
	logic [SH_W-1:0]       shifted_c;
	logic [2*MANT_W-1:0]   sq_c;
	logic [MANT_W:0]       t_c;
	logic [EX_W-1:0]       diff_c;
	logic [MAG_W-1:0]      mag_c;
	logic [PROD_W-1:0]     prod_c;
	logic [RND_W-1:0]      rnd_c;
	logic [R_W-1:0]        r_c;
	logic [R_W-1:0]        r_sat_c;
	logic [vpp_pkg::LOG_W-1:0] log_c;
	logic                  out_free;

	assign {last_in, idx_in, p_in} = q_data;
	assign pop      = (state_q == B_IDLE) && q_valid;
	assign out_free = !result_valid_q || result_ready;

	always_comb begin
		lead_c = '0;
		for (int i = 0; i < PROB_BITS; i++) begin
			if (p_in[i]) begin
				lead_c = E_W'(i);
			end
		end
	end

	// Mantissa in [2^15, 2^16): the leading one lands on bit 15.
	assign shifted_c = (SH_W'(p_in) << (MANT_W - 1)) >> lead_c;

	// Each squaring step doubles the exponent, so its overflow bit is the
	// next fraction bit of log2.
	assign sq_c = y_q * y_q;
	assign t_c  = sq_c[2*MANT_W-1:MANT_W-1];

	assign diff_c = EX_W'(PROB_BITS) - EX_W'(e_q);
	assign mag_c  = {diff_c, MANT_W'(0)} - MAG_W'(frac_q);
	assign prod_c = PROD_W'(mag_c) * PROD_W'(vpp_pkg::LN2_Q16);

	assign rnd_c   = RND_W'(prod_q) + ROUND_HALF;
	assign r_c     = rnd_c[RND_W-1:vpp_pkg::ROUND_SH];
	assign r_sat_c = (r_c > R_SAT) ? R_SAT : r_c;
	assign log_c   = zero_q ? vpp_pkg::LOG_MIN : (~r_sat_c[vpp_pkg::LOG_W-1:0] + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_IDLE;
			step_q         <= '0;
			result_valid_q <= 1'b0;
			token_index_q  <= '0;
			log_q          <= '0;
			last_result_q  <= 1'b0;
		end else begin
			if (result_ready && !(state_q == B_OUT && out_free)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					step_q <= '0;
					if (q_valid) begin
						state_q <= (p_in == '0) ? B_OUT : B_SQ;
					end
				end
				B_SQ: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(vpp_pkg::SQ_STEPS - 1)) begin
						state_q <= B_MUL;
					end
				end
				B_MUL: state_q <= B_OUT;
				B_OUT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						token_index_q  <= idx_q;
						log_q          <= log_c;
						last_result_q  <= last_q;
						state_q        <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			y_q    <= shifted_c[MANT_W-1:0];
			e_q    <= lead_c;
			frac_q <= '0;
			zero_q <= (p_in == '0);
			idx_q  <= idx_in;
			last_q <= last_in;
		end else if (state_q == B_SQ) begin
			y_q    <= t_c[MANT_W] ? t_c[MANT_W:1] : t_c[MANT_W-1:0];
			frac_q <= {frac_q[MANT_W-2:0], t_c[MANT_W]};
		end
		if (state_q == B_MUL) begin
			prod_q <= prod_c;
		end
	end

	assign result_valid    = result_valid_q;
	assign token_index     = vpp_pkg::INDEX_OUT_W'(token_index_q);
	assign log_probability = log_q;
	assign last_result     = last_result_q;

endmodule

`default_nettype wire

// ----- design/vocab_prob_prune_topk_cumulative.sv -----
// Top level of the vocabulary probability pruning block (top-n and cumulative cutoff).
//
// Entries of one time step arrive on the entry channel (probability, last_entry) with
// valid/ready, one per cycle; each is placed into a sorted cell row on arrival. Entries
// past VOCAB_SIZE in one step are dropped, but their last_entry flag still counts.
// After the last entry the kept entries leave on the result channel (token_index,
// log_probability, last_result), sorted or in arrival order, last_result on the final.
// The entry channel then stays not ready while the kept entries are selected and
// queued, one per cycle into a four-deep queue while it has room. Each result with a
// nonzero probability passes the log unit in order: load, 16 squaring steps on one
// 16x16 multiplier, one scaling multiply, round and register; a zero probability goes
// from load straight to round and register. The log unit takes the next entry from the
// queue only after the last result is registered. A stalled result channel holds the
// output register; the log unit and the queue then fill and the selection pauses, so
// nothing is lost or repeated. Reset clears all control state and sets
// cutoff_probability to 1.0 and keep_top_n to 64; the configuration registers are to be
// written over the APB-style port only while idle, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module vocab_prob_prune_topk_cumulative #(
	parameter int VOCAB_SIZE = vpp_pkg::VOCAB_SIZE_DEF,
	parameter int PROB_BITS  = vpp_pkg::PROB_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [vpp_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [vpp_pkg::DATA_W-1:0]        pwdata,
	output logic      [vpp_pkg::DATA_W-1:0]        prdata,
	output logic                                   pready,
	input  wire logic                              entry_valid,
	output logic                                   entry_ready,
	input  wire logic [PROB_BITS-1:0]              probability,
	input  wire logic                              last_entry,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output logic      [vpp_pkg::INDEX_OUT_W-1:0]   token_index,
	output logic signed [vpp_pkg::LOG_W-1:0]       log_probability,
	output logic                                   last_result
);

	localparam int IDX_W = $clog2(VOCAB_SIZE);
	localparam int PKT_W = 1 + IDX_W + PROB_BITS;

	logic [PROB_BITS:0]           cutoff;
	logic [vpp_pkg::TOPN_W-1:0]   keep_top_n;
	logic                         push;
	logic [PKT_W-1:0]             push_data;
	logic                         pop;
	logic [PKT_W-1:0]             pop_data;
	logic                         q_valid;
	logic [vpp_pkg::QLVL_W-1:0]   q_level;

	vpp_cfg #(
		.PROB_BITS (PROB_BITS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cutoff     (cutoff),
		.keep_top_n (keep_top_n)
	);

	vpp_front #(
		.VOCAB_SIZE (VOCAB_SIZE),
		.PROB_BITS  (PROB_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (entry_valid),
		.entry_ready (entry_ready),
		.probability (probability),
		.last_entry  (last_entry),
		.cutoff      (cutoff),
		.keep_top_n  (keep_top_n),
		.q_level     (q_level),
		.push        (push),
		.push_data   (push_data)
	);

	vpp_queue #(
		.PKT_W (PKT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_valid),
		.level     (q_level)
	);

	vpp_back #(
		.VOCAB_SIZE (VOCAB_SIZE),
		.PROB_BITS  (PROB_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_data          (pop_data),
		.pop             (pop),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.token_index     (token_index),
		.log_probability (log_probability),
		.last_result     (last_result)
	);

endmodule

`default_nettype wire

// ----- design/vpp_checker.sv -----
// Port-level checker of the vocabulary pruning block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "vocab_prob_prune_topk_cumulative_defines.svh"

module vpp_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              psel,
	input wire logic                              penable,
	input wire logic                              pwrite,
	input wire logic [vpp_pkg::ADDR_W-1:0]        paddr,
	input wire logic [vpp_pkg::DATA_W-1:0]        pwdata,
	input wire logic [vpp_pkg::DATA_W-1:0]        prdata,
	input wire logic                              entry_valid,
	input wire logic                              entry_ready,
	input wire logic                              last_entry,
	input wire logic                              result_valid,
	input wire logic                              result_ready,
	input wire logic [vpp_pkg::INDEX_OUT_W-1:0]   token_index,
	input wire logic [vpp_pkg::LOG_W-1:0]         log_probability,
	input wire logic                              last_result
);

	// A result waiting on the receiver stays put.
	`VPP_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(token_index) && $stable(log_probability) && $stable(last_result))

	// Coming out of reset, nothing is pending and entries are taken.
	`VPP_ASSERT_IMP(a_reset_clean, $rose(arst_n), !result_valid && entry_ready)

	// Loading continues until the entry flagged last arrives.
	`VPP_ASSERT_NXT(a_load_continues, entry_valid && entry_ready && !last_entry, entry_ready)

	// A write to the keep_top_n register is visible on its read data right after it.
	`VPP_ASSERT_NXT(a_keep_readback, psel && penable && pwrite && paddr == vpp_pkg::ADDR_KEEP_TOP_N, paddr != vpp_pkg::ADDR_KEEP_TOP_N || prdata[6:0] == $past(pwdata[6:0]))

endmodule

bind vocab_prob_prune_topk_cumulative vpp_checker u_vpp_checker (.*);

`default_nettype wire
